### design/ssha_pkg.sv
// Shared types and constants for the sparse-set handle allocator.
// Holds the table geometry, the request and status codes and the controller states.
// Used by ssha_ram and sparse_set_handle_allocator_unit; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ssha_pkg;

  // Table geometry
  localparam int INDEX_BITS  = 12;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int CNT_W       = INDEX_BITS + 1;

  // Field widths
  localparam int HANDLE_W   = 16;
  localparam int KIND_W     = 4;
  localparam int KIND_SHIFT = 12;
  localparam int CAP_W      = 13;
  localparam int COUNT_W    = 13;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_KIND     = 1'b1;
  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(4096);
  localparam logic [KIND_W-1:0] KIND_RESET = '0;

  // Request codes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_LIVE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

  localparam logic [HANDLE_W-1:0] FAIL_HANDLE = '1;

  // One write port of a table memory
  typedef struct packed {
    logic                  we;
    logic [INDEX_BITS-1:0] addr;
    logic [INDEX_BITS-1:0] data;
  } ssha_wr_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_RD2,
    ST_CHK,
    ST_WR2
  } ssha_state_e;

endpackage

`default_nettype wire

### design/ssha_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
// Used for both the dense and the sparse table; depends on ssha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssha_ram
  import ssha_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire ssha_wr_t              wr_i,
  input  wire logic [INDEX_BITS-1:0] raddr_i,
  output logic      [INDEX_BITS-1:0] rdata_o
);

  logic [INDEX_BITS-1:0] mem [TABLE_DEPTH];
  logic [INDEX_BITS-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/sparse_set_handle_allocator_unit.sv
// Sparse-set handle allocator: dense/sparse table pair under a small sequencer.
// After reset an init pass loads both tables as identity maps; input stalls meanwhile,
// configuration writes are taken. Full, empty-free and unused requests are answered from
// ST_IDLE; allocate goes through ST_RD to ST_RD2, query and a rejected free on to ST_CHK,
// a free that swaps on to ST_WR2. One request at a time: the next beat is taken only once
// the sequencer is back in ST_IDLE and the result register is free. Depends on ssha_pkg
// and ssha_ram.
`timescale 1ns / 1ps
`default_nettype none

module sparse_set_handle_allocator_unit
  import ssha_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready,
  // request channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [HANDLE_W-1:0] handle_in_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [HANDLE_W-1:0] handle_out_o,
  output logic      [STATUS_W-1:0] status_o,
  output logic                     is_live_o,
  output logic      [COUNT_W-1:0]  live_count_o
);

  localparam logic [CAP_W-1:0]      DEPTH_CAP = CAP_W'(TABLE_DEPTH);
  localparam logic [INDEX_BITS-1:0] IDX_LAST  = INDEX_BITS'(TABLE_DEPTH - 1);

  // configuration registers
  logic [CAP_W-1:0]  cap_q;
  logic [KIND_W-1:0] kind_q;

  // sequencer state
  ssha_state_e           state_q, state_d;
  logic [INDEX_BITS-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]      live_q, live_d;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [INDEX_BITS-1:0] dpos_q, dpos_d;
  logic [INDEX_BITS-1:0] s2_q, s2_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [HANDLE_W-1:0] hout_q, hout_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic                live_flag_q, live_flag_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;

  // table ports
  ssha_wr_t              dense_wr, sparse_wr;
  logic [INDEX_BITS-1:0] dense_raddr, sparse_raddr;
  logic [INDEX_BITS-1:0] dense_rdata, sparse_rdata;

  // shared comparator and helpers
  logic [CNT_W-1:0]      cmp_a, cmp_b;
  logic                  cmp_ge;
  logic [CAP_W-1:0]      eff_cap13;
  logic [CNT_W-1:0]      eff_cap;
  logic [CNT_W-1:0]      top_w;
  logic [INDEX_BITS-1:0] top;
  logic                  slot_free;
  logic                  in_fire;
  logic                  emit;
  logic                  hit;
  logic                  cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      kind_q <= KIND_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CAPACITY: cap_q  <= pwdata[CAP_W-1:0];
        REG_KIND:     kind_q <= pwdata[KIND_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CAPACITY: prdata = DATA_W'(cap_q);
      REG_KIND:     prdata = DATA_W'(kind_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tables
  ssha_ram u_dense (
    .clk_i   (clk_i),
    .wr_i    (dense_wr),
    .raddr_i (dense_raddr),
    .rdata_o (dense_rdata)
  );

  ssha_ram u_sparse (
    .clk_i   (clk_i),
    .wr_i    (sparse_wr),
    .raddr_i (sparse_raddr),
    .rdata_o (sparse_rdata)
  );

  // ---------------------------------------------------------------------------
  // Derived values
  assign eff_cap13 = (cap_q > DEPTH_CAP) ? DEPTH_CAP : cap_q;
  assign eff_cap   = eff_cap13[CNT_W-1:0];
  assign top_w     = live_q - CNT_W'(1);
  assign top       = top_w[INDEX_BITS-1:0];
  assign cmp_ge    = (cmp_a >= cmp_b);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && slot_free);
  assign in_fire   = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Sequencer: next state, table accesses and result
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    live_d      = live_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    dpos_d      = dpos_q;
    s2_d        = s2_q;
    out_valid_d = out_valid_q && out_stall_i;
    hout_d      = hout_q;
    stat_d      = stat_q;
    live_flag_d = live_flag_q;
    cnt_d       = cnt_q;
    emit        = 1'b0;
    hit         = 1'b0;
    dense_wr    = '0;
    sparse_wr   = '0;
    dense_raddr = dpos_q;
    sparse_raddr = idx_q;
    cmp_a       = live_q;
    cmp_b       = eff_cap;

    unique case (state_q)
      // identity load of both tables
      ST_CLEAR: begin
        dense_wr  = '{we: 1'b1, addr: clr_q, data: clr_q};
        sparse_wr = '{we: 1'b1, addr: clr_q, data: clr_q};
        clr_d     = clr_q + INDEX_BITS'(1);
        if (clr_q == IDX_LAST) begin
          state_d = ST_IDLE;
        end
      end

      // take a request; trivial answers go out at once
      ST_IDLE: begin
        if (in_fire) begin
          mode_d = mode_i;
          idx_d  = handle_in_i[INDEX_BITS-1:0];
          hout_d = handle_in_i;
          stat_d = STAT_OK;
          live_flag_d = 1'b0;
          case (mode_i)
            MODE_ALLOC: begin
              if (cmp_ge) begin
                emit   = 1'b1;
                hout_d = FAIL_HANDLE;
                stat_d = STAT_FULL;
              end else begin
                state_d = ST_RD;
              end
            end
            MODE_FREE: begin
              if (live_q == '0) begin
                emit   = 1'b1;
                stat_d = STAT_EMPTY;
              end else begin
                state_d = ST_RD;
              end
            end
            MODE_QUERY: state_d = ST_RD;
            default:    emit = 1'b1;
          endcase
        end
      end

      // first reads: sparse[idx], dense[count] or dense[top]
      ST_RD: begin
        dense_raddr = (mode_q == MODE_ALLOC) ? live_q[INDEX_BITS-1:0] : top;
        state_d     = ST_RD2;
      end

      // allocate answers here; free/query fetch dense[sparse[idx]]
      ST_RD2: begin
        if (mode_q == MODE_ALLOC) begin
          dense_raddr = live_q[INDEX_BITS-1:0];
          if (slot_free) begin
            emit    = 1'b1;
            live_d  = live_q + CNT_W'(1);
            hout_d  = HANDLE_W'(dense_rdata) | (HANDLE_W'(kind_q) << KIND_SHIFT);
            stat_d  = STAT_OK;
            state_d = ST_IDLE;
          end
        end else begin
          dpos_d      = sparse_rdata;
          s2_d        = dense_rdata;
          dense_raddr = sparse_rdata;
          state_d     = ST_CHK;
        end
      end

      // liveness check; free does its first swap write here
      ST_CHK: begin
        dense_raddr = dpos_q;
        cmp_a = CNT_W'(dpos_q);
        cmp_b = live_q;
        hit   = !cmp_ge && (dense_rdata == idx_q);
        if (mode_q == MODE_QUERY) begin
          if (slot_free) begin
            emit        = 1'b1;
            stat_d      = STAT_OK;
            live_flag_d = hit;
            state_d     = ST_IDLE;
          end
        end else if (!hit) begin
          if (slot_free) begin
            emit    = 1'b1;
            stat_d  = STAT_NOT_LIVE;
            state_d = ST_IDLE;
          end
        end else begin
          dense_wr  = '{we: 1'b1, addr: dpos_q, data: s2_q};
          sparse_wr = '{we: 1'b1, addr: s2_q, data: dpos_q};
          state_d   = ST_WR2;
        end
      end

      // second swap write, count down, answer
      ST_WR2: begin
        if (slot_free) begin
          dense_wr  = '{we: 1'b1, addr: top, data: idx_q};
          sparse_wr = '{we: 1'b1, addr: idx_q, data: top};
          live_d    = top_w;
          emit      = 1'b1;
          stat_d    = STAT_OK;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      cnt_d       = COUNT_W'(live_d);
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    idx_q       <= idx_d;
    dpos_q      <= dpos_d;
    s2_q        <= s2_d;
    hout_q      <= hout_d;
    stat_q      <= stat_d;
    live_flag_q <= live_flag_d;
    cnt_q       <= cnt_d;
  end

  assign out_valid_o  = out_valid_q;
  assign handle_out_o = hout_q;
  assign status_o     = stat_q;
  assign is_live_o    = live_flag_q;
  assign live_count_o = cnt_q;

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sparse_set_handle_allocator_unit: a directed part, a
// back-pressure run and random request mixes, all checked against an in-bench predictor.
// Depends on ssha_pkg and the design sources.

module testbench;
  import ssha_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned SETTLE      = 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] CAP_ADDR  = ADDR_W'(4 * int'(REG_CAPACITY));
  localparam logic [ADDR_W-1:0] KIND_ADDR = ADDR_W'(4 * int'(REG_KIND));

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [STATUS_W-1:0] status;
    logic                live;
    logic [COUNT_W-1:0]  count;
  } alloc_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [MODE_W-1:0]   mode_i = MODE_ALLOC;
  logic [HANDLE_W-1:0] handle_in_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [HANDLE_W-1:0] handle_out_o;
  logic [STATUS_W-1:0] status_o;
  logic                is_live_o;
  logic [COUNT_W-1:0]  live_count_o;

  // Predictor state: slot -> index and index -> slot maps, live count, registers
  logic [INDEX_BITS-1:0] slot_to_index [TABLE_DEPTH];
  logic [INDEX_BITS-1:0] index_to_slot [TABLE_DEPTH];
  logic [CNT_W-1:0]      live_handles = '0;
  logic [CAP_W-1:0]      cap_limit = CAP_RESET;
  logic [KIND_W-1:0]     kind_code = KIND_RESET;

  alloc_result_t pending_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  bit            tx_idle_en = 1'b1;
  bit            rx_idle_en = 1'b1;
  logic          hold_on;
  event          hold_req;

  sparse_set_handle_allocator_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .handle_in_i  (handle_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .handle_out_o (handle_out_o),
    .status_o     (status_o),
    .is_live_o    (is_live_o),
    .live_count_o (live_count_o)
  );

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering beats
  initial begin
    hold_on = 1'b0;
    forever begin
      @(hold_req);
      @(posedge clk_i);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // Index is live when its slot lies below the count and maps back to it
  function automatic logic index_is_live(input logic [INDEX_BITS-1:0] idx);
    logic [INDEX_BITS-1:0] slot;
    slot = index_to_slot[idx];
    return (CNT_W'(slot) < live_handles) && (slot_to_index[slot] == idx);
  endfunction

  // Applies one request to the predictor state and returns the expected result
  function automatic alloc_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                  input logic [HANDLE_W-1:0] handle);
    alloc_result_t         res;
    logic [INDEX_BITS-1:0] idx, slot, top, moved;
    logic [CNT_W-1:0]      cap_eff;
    idx        = handle[INDEX_BITS-1:0];
    res.handle = handle;
    res.status = STAT_OK;
    res.live   = 1'b0;
    cap_eff    = (cap_limit > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cap_limit);
    case (mode)
      MODE_ALLOC: begin
        if (live_handles >= cap_eff || live_handles >= TABLE_DEPTH) begin
          res.handle = FAIL_HANDLE;
          res.status = STAT_FULL;
        end else begin
          slot         = slot_to_index[live_handles[INDEX_BITS-1:0]];
          live_handles = live_handles + 1'b1;
          res.handle   = {kind_code, slot};
        end
      end
      MODE_FREE: begin
        if (live_handles == 0) begin
          res.status = STAT_EMPTY;
        end else if (!index_is_live(idx)) begin
          res.status = STAT_NOT_LIVE;
        end else begin
          // swap the freed entry with the last live slot
          slot                 = index_to_slot[idx];
          top                  = INDEX_BITS'(live_handles - 1'b1);
          moved                = slot_to_index[top];
          slot_to_index[slot]  = moved;
          index_to_slot[moved] = slot;
          slot_to_index[top]   = idx;
          index_to_slot[idx]   = top;
          live_handles         = live_handles - 1'b1;
        end
      end
      MODE_QUERY: res.live = index_is_live(idx);
      default: ;
    endcase
    res.count = live_handles;
    return res;
  endfunction

  // Some live handle, with the given upper bits
  function automatic logic [HANDLE_W-1:0] pick_live(input logic [HANDLE_W-1:0] handle);
    return {handle[HANDLE_W-1:INDEX_BITS],
            slot_to_index[$urandom_range(int'(live_handles) - 1)]};
  endfunction

  // Result check: every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    alloc_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{handle_out_o, status_o, is_live_o, live_count_o};
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result with nothing pending: handle %h status %0d live %0b count %0d",
                   $realtime, got.handle, got.status, got.live, got.count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.handle !== want.handle || got.status !== want.status ||
            got.live !== want.live || got.count !== want.count) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch exp handle %h status %0d live %0b count %0d, got %h %0d %0b %0d",
                     $realtime, want.handle, want.status, want.live, want.count,
                     got.handle, got.status, got.live, got.count);
          mismatch_count++;
        end
      end
    end
    // receiver stall
    if (!rst_ni)
      out_stall_i <= 1'b0;
    else if (hold_on)
      out_stall_i <= 1'b1;
    else if (rx_idle_en)
      out_stall_i <= ($urandom_range(99) < IDLE_PCT);
    else
      out_stall_i <= 1'b0;
  end

  // One request beat, with random gaps ahead of it while tx_idle_en is set; prediction at acceptance
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] handle);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    handle_in_i <= handle;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_request(mode, handle));
  endtask

  // Drain: no request offered, every result back, then a settle wait
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // APB write: setup then access, taken at the edge with pready high
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == CAP_ADDR)
      cap_limit = data[CAP_W-1:0];
    else if (addr == KIND_ADDR)
      kind_code = data[KIND_W-1:0];
  endtask

  // Default registers: empty free, unused mode, allocate, swap on free, queries
  task automatic test_empty_table();
    send_request(MODE_QUERY, 16'h0000);
    send_request(MODE_FREE, 16'hFFFF);
    send_request(MODE_UNUSED, 16'hA5A5);
    send_request(MODE_ALLOC, 16'hFFFF);
    send_request(MODE_ALLOC, 16'h0000);
    send_request(MODE_ALLOC, 16'h5A5A);
    send_request(MODE_QUERY, 16'hF001);
    send_request(MODE_QUERY, 16'h0FFF);
    send_request(MODE_FREE, 16'h0005);
    send_request(MODE_FREE, 16'hF000);
    send_request(MODE_QUERY, 16'h0000);
    send_request(MODE_ALLOC, 16'h1234);
  endtask

  // Kind extremes, capacity one, zero, below the live count and above table size
  task automatic test_kind_and_capacity();
    wait_idle();
    write_reg(KIND_ADDR, 32'hF);
    write_reg(CAP_ADDR, 32'd1);
    send_request(MODE_ALLOC, 16'h0000);
    send_request(MODE_FREE, pick_live(16'hFFFF));
    send_request(MODE_QUERY, pick_live(16'h0000));
    send_request(MODE_FREE, pick_live(16'h8000));
    send_request(MODE_ALLOC, 16'hFFFF);
    send_request(MODE_FREE, pick_live(16'h0000));
    send_request(MODE_ALLOC, 16'h0000);
    send_request(MODE_ALLOC, 16'h0000);
    wait_idle();
    write_reg(CAP_ADDR, 32'd0);
    send_request(MODE_ALLOC, 16'h0000);
    wait_idle();
    write_reg(CAP_ADDR, 32'h1FFF);
    write_reg(KIND_ADDR, 32'h0);
    send_request(MODE_ALLOC, 16'hFFFF);
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    wait_idle();
    write_reg(CAP_ADDR, 32'd4096);
    tx_idle_en = 1'b0;
    -> hold_req;
    repeat (24) begin
      if (live_handles != 0 && $urandom_range(2) == 0)
        send_request(MODE_FREE, pick_live(HANDLE_W'($urandom)));
      else
        send_request(MODE_ALLOC, HANDLE_W'($urandom));
    end
    tx_idle_en = 1'b1;
  endtask

  // Random beats; frees mostly and queries half the time aim at live handles
  task automatic run_mix(input int unsigned beats, input int unsigned alloc_pct);
    int unsigned         roll, free_end;
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle;
    free_end = alloc_pct + (97 - alloc_pct) * 3 / 5;
    repeat (beats) begin
      roll   = $urandom_range(99);
      handle = HANDLE_W'($urandom);
      if (roll < alloc_pct) begin
        mode = MODE_ALLOC;
      end else if (roll < free_end) begin
        mode = MODE_FREE;
        if (live_handles != 0 && $urandom_range(9) < 8) handle = pick_live(handle);
      end else if (roll < 97) begin
        mode = MODE_QUERY;
        if (live_handles != 0 && $urandom_range(1) == 1) handle = pick_live(handle);
      end else begin
        mode = MODE_UNUSED;
      end
      send_request(mode, handle);
    end
  endtask

  // Random phases across register settings, one without any idling
  task automatic test_random_mix();
    wait_idle();
    write_reg(CAP_ADDR, 32'd4096);
    write_reg(KIND_ADDR, DATA_W'($urandom_range(15)));
    run_mix(250, 55);
    wait_idle();
    write_reg(CAP_ADDR, DATA_W'($urandom_range(9, 2)));
    write_reg(KIND_ADDR, 32'hF);
    run_mix(200, 45);
    wait_idle();
    write_reg(CAP_ADDR, 32'd4096);
    write_reg(KIND_ADDR, 32'h0);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_mix(150, 50);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_idle();
    write_reg(CAP_ADDR, 32'd0);
    write_reg(KIND_ADDR, DATA_W'($urandom_range(15)));
    run_mix(80, 30);
    wait_idle();
    write_reg(CAP_ADDR, 32'h1FFF);
    write_reg(KIND_ADDR, DATA_W'($urandom_range(15)));
    run_mix(170, 50);
  endtask

  // Sequence
  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_to_index[i] = INDEX_BITS'(i);
      index_to_slot[i] = INDEX_BITS'(i);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_kind_and_capacity();
    test_backpressure();
    test_random_mix();
    wait_idle();
    if (mismatch_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
